[hdl/rtc_pkg.sv]
package rtc_pkg;

  localparam int InDataW  = 56;
  localparam int InUserW  = 3;
  localparam int OutDataW = 64;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  localparam logic [15:0] DefMinYear      = 16'd2000;
  localparam logic [15:0] DefMaxYear      = 16'd2099;
  localparam logic [2:0]  DefResetWeekday = 3'd6;
  localparam logic [4:0]  DefMinMod25     = 5'(DefMinYear % 25);
  localparam int          DefQueueDepth   = 4;

  localparam logic [CfgAddrW-1:0] RegMinYear      = 2'd0;
  localparam logic [CfgAddrW-1:0] RegMaxYear      = 2'd1;
  localparam logic [CfgAddrW-1:0] RegResetWeekday = 2'd2;

  localparam logic [InUserW-1:0] KindTick     = 3'd0;
  localparam logic [InUserW-1:0] KindSetTime  = 3'd1;
  localparam logic [InUserW-1:0] KindSetDate  = 3'd2;
  localparam logic [InUserW-1:0] KindSetAlarm = 3'd3;
  localparam logic [InUserW-1:0] KindClear    = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET_TIME,
    OP_SET_DATE,
    OP_SET_ALARM,
    OP_CLEAR,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [16:0] wd_sum;
    logic [4:0]  year_mod25;
  } cmd_t;

  typedef struct packed {
    logic [15:0] year_lo;
    logic [15:0] year_hi;
    logic [2:0]  reset_weekday;
    logic [4:0]  min_mod25;
  } cfg_t;

  function automatic logic [2:0] sak_offset(input logic [3:0] month);
    logic [2:0] t;
    case (month)
      4'd1:    t = 3'd0;
      4'd2:    t = 3'd3;
      4'd3:    t = 3'd2;
      4'd4:    t = 3'd5;
      4'd5:    t = 3'd0;
      4'd6:    t = 3'd3;
      4'd7:    t = 3'd5;
      4'd8:    t = 3'd1;
      4'd9:    t = 3'd4;
      4'd10:   t = 3'd6;
      4'd11:   t = 3'd2;
      4'd12:   t = 3'd4;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month)
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  // floor(x / 25) for x below 2^14
  function automatic logic [9:0] div25_14(input logic [13:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(5243);
    return p[26:17];
  endfunction

  function automatic logic [4:0] mod25_16(input logic [15:0] x);
    logic [32:0] p;
    logic [11:0] q;
    logic [15:0] qx25;
    p    = 33'(x) * 33'(83887);
    q    = p[32:21];
    qx25 = 16'({q, 4'd0}) + 16'({q, 3'd0}) + 16'(q);
    return 5'(x - qx25);
  endfunction

  // fold octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7_17(input logic [16:0] x);
    logic [5:0] a;
    logic [3:0] b;
    logic [3:0] c;
    a = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[16:15]);
    b = 4'(a[2:0]) + 4'(a[5:3]);
    c = 4'(b[2:0]) + 4'(b[3]);
    return (c >= 4'd7) ? 3'(c - 4'd7) : c[2:0];
  endfunction

endpackage

[hdl/rtc_calendar_with_alarm_unit.sv]
// Channel  Signals                          Payload
// s_*      s_tvalid s_tready s_tdata s_tuser  request: kind in tuser, time/date fields in tdata
// m_*      m_tvalid m_tready m_tdata          result: flag, time, date, weekday, alarm
// cfg_*    cfg_we cfg_addr cfg_data           year floor, year ceiling, reset weekday
//
// One request per cycle sustained while m_tready stays high.
// Queue write at the input transfer; state update and result load when the request leaves the queue.
// The request queue (QueueDepth entries) decouples the decode side from the state update.
// s_tready drops only when the queue is full; m_tready low holds the result register while m_tvalid is high.
// rst is synchronous: calendar 00:00:00, 1 January of the year floor, alarm disarmed.
module rtc_calendar_with_alarm_unit #(
  parameter int QueueDepth = rtc_pkg::DefQueueDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // hour_in, minute_in, second_in, day_in, month_in, year_in
  input  logic [rtc_pkg::InDataW-1:0]   s_tdata,
  // kind
  input  logic [rtc_pkg::InUserW-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // accepted, second_now, minute_now, hour_now, day_now, month_now, year_now,
  // weekday_now, alarm_hour_now, alarm_minute_now, alarm_armed, alarm_active, zero pad
  output logic [rtc_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          cfg_we,
  input  logic [rtc_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [rtc_pkg::CfgDataW-1:0]  cfg_data
);
  import rtc_pkg::*;

  logic [15:0] year_lo;
  logic [15:0] year_hi;
  logic [2:0]  reset_weekday;
  cfg_t        cfg;
  logic        full;
  logic        push;
  cmd_t        push_cmd;
  logic        q_valid;
  logic        pop;
  cmd_t        head;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_lo       <= DefMinYear;
      year_hi       <= DefMaxYear;
      reset_weekday <= DefResetWeekday;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegMinYear:      year_lo       <= cfg_data;
        RegMaxYear:      year_hi       <= cfg_data;
        RegResetWeekday: reset_weekday <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.year_lo       = year_lo;
  assign cfg.year_hi       = year_hi;
  assign cfg.reset_weekday = reset_weekday;
  assign cfg.min_mod25     = mod25_16(year_lo);

  rtc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .full     (full),
    .push     (push),
    .cmd      (push_cmd)
  );

  rtc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .valid     (q_valid),
    .pop       (pop),
    .head      (head)
  );

  rtc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .pop      (pop),
    .cmd      (head),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[hdl/rtc_front.sv]
module rtc_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // hour_in, minute_in, second_in, day_in, month_in, year_in
  input  logic [rtc_pkg::InDataW-1:0]  s_tdata,
  // kind
  input  logic [rtc_pkg::InUserW-1:0]  s_tuser,
  input  rtc_pkg::cfg_t                cfg,
  input  logic                         full,
  output logic                         push,
  output rtc_pkg::cmd_t                cmd
);
  import rtc_pkg::*;

  logic [7:0]  hour_in;
  logic [7:0]  minute_in;
  logic [7:0]  second_in;
  logic [7:0]  day_in;
  logic [7:0]  month_in;
  logic [15:0] year_in;
  logic        time_ok;
  logic        date_ok;
  logic [15:0] sy;
  logic [9:0]  q100;
  logic [9:0]  q400;

  assign hour_in   = s_tdata[7:0];
  assign minute_in = s_tdata[15:8];
  assign second_in = s_tdata[23:16];
  assign day_in    = s_tdata[31:24];
  assign month_in  = s_tdata[39:32];
  assign year_in   = s_tdata[55:40];

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  assign time_ok = (hour_in <= 8'd23) && (minute_in <= 8'd59);
  assign date_ok = (day_in >= 8'd1) && (day_in <= 8'd31) && (month_in >= 8'd1) &&
                   (month_in <= 8'd12) && (year_in >= cfg.year_lo) &&
                   (year_in <= cfg.year_hi);

  assign sy   = (month_in < 8'd3) ? year_in - 16'd1 : year_in;
  assign q100 = div25_14(sy[15:2]);
  assign q400 = div25_14({2'd0, sy[15:4]});

  always_comb begin
    cmd.hour       = hour_in[4:0];
    cmd.minute     = minute_in[5:0];
    cmd.second     = second_in[5:0];
    cmd.day        = day_in[4:0];
    cmd.month      = month_in[3:0];
    cmd.year       = year_in;
    cmd.year_mod25 = mod25_16(year_in);
    cmd.wd_sum     = 17'(18'(sy) + 18'(sy[15:2]) + 18'(q400) + 18'(sak_offset(month_in[3:0]))
                     + 18'(day_in[4:0]) - 18'(q100));
    case (s_tuser)
      KindTick:     cmd.op = OP_TICK;
      KindSetTime:  cmd.op = (time_ok && second_in <= 8'd59) ? OP_SET_TIME : OP_REJECT;
      KindSetDate:  cmd.op = date_ok ? OP_SET_DATE : OP_REJECT;
      KindSetAlarm: cmd.op = time_ok ? OP_SET_ALARM : OP_REJECT;
      KindClear:    cmd.op = OP_CLEAR;
      default:      cmd.op = OP_REJECT;
    endcase
  end

endmodule

[hdl/rtc_queue.sv]
module rtc_queue #(
  parameter int Depth = rtc_pkg::DefQueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rtc_pkg::cmd_t push_data,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output rtc_pkg::cmd_t head
);
  import rtc_pkg::*;

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slots [Depth];
  logic [IdxW-1:0] wr_ptr;
  logic [IdxW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IdxW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IdxW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CntW'(Depth))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on push");
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

[hdl/rtc_back.sv]
module rtc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  rtc_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  output logic                         pop,
  input  rtc_pkg::cmd_t                cmd,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // accepted, second_now, minute_now, hour_now, day_now, month_now, year_now,
  // weekday_now, alarm_hour_now, alarm_minute_now, alarm_armed, alarm_active, zero pad
  output logic [rtc_pkg::OutDataW-1:0] m_tdata
);
  import rtc_pkg::*;

  logic [5:0]  seconds, seconds_next;
  logic [5:0]  minutes, minutes_next;
  logic [4:0]  hours, hours_next;
  logic [4:0]  day_of_month, day_of_month_next;
  logic [3:0]  month, month_next;
  logic [15:0] year, year_next;
  logic [4:0]  year_mod25, year_mod25_next;
  logic [2:0]  weekday, weekday_next;
  logic [4:0]  alarm_hour, alarm_hour_next;
  logic [5:0]  alarm_minute, alarm_minute_next;
  logic        armed_flag, armed_flag_next;
  logic        active_flag, active_flag_next;

  logic        sec_wrap;
  logic        min_wrap;
  logic        hour_wrap;
  logic        carry;
  logic        leap;
  logic [5:0]  day_sum;
  logic [3:0]  wd_sum;
  logic        wrapped;
  logic        accepted;

  assign pop = q_valid && (!m_tvalid || m_tready);

  assign sec_wrap  = seconds >= 6'd59;
  assign min_wrap  = minutes >= 6'd59;
  assign hour_wrap = hours >= 5'd23;
  assign carry     = sec_wrap && min_wrap && hour_wrap;
  assign leap      = (year[1:0] == 2'd0 && year_mod25 != 5'd0) ||
                     (year[3:0] == 4'd0 && year_mod25 == 5'd0);
  assign day_sum   = 6'(day_of_month) + 6'(carry);
  assign wd_sum    = 4'(weekday) + 4'(carry);
  assign accepted  = (cmd.op != OP_REJECT);

  always_comb begin
    seconds_next      = seconds;
    minutes_next      = minutes;
    hours_next        = hours;
    day_of_month_next = day_of_month;
    month_next        = month;
    year_next         = year;
    year_mod25_next   = year_mod25;
    weekday_next      = weekday;
    alarm_hour_next   = alarm_hour;
    alarm_minute_next = alarm_minute;
    armed_flag_next   = armed_flag;
    active_flag_next  = active_flag;
    wrapped           = 1'b0;
    case (cmd.op)
      OP_TICK: begin
        if (!sec_wrap) begin
          seconds_next = seconds + 6'd1;
        end else begin
          seconds_next = '0;
          if (!min_wrap) begin
            minutes_next = minutes + 6'd1;
          end else begin
            minutes_next = '0;
            hours_next   = hour_wrap ? 5'd0 : hours + 5'd1;
          end
        end
        if (day_sum > 6'(days_in_month(month, leap))) begin
          day_of_month_next = 5'd1;
          if (month < 4'd12) begin
            month_next = month + 4'd1;
          end else begin
            month_next = 4'd1;
            if (year < cfg.year_hi) begin
              year_next       = year + 16'd1;
              year_mod25_next = (year_mod25 >= 5'd24) ? 5'd0 : year_mod25 + 5'd1;
            end else begin
              wrapped = 1'b1;
            end
          end
        end else begin
          day_of_month_next = day_sum[4:0];
        end
        weekday_next = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
        if (wrapped) begin
          seconds_next      = '0;
          minutes_next      = '0;
          hours_next        = '0;
          day_of_month_next = 5'd1;
          month_next        = 4'd1;
          year_next         = cfg.year_lo;
          year_mod25_next   = cfg.min_mod25;
          weekday_next      = cfg.reset_weekday;
        end
        if (armed_flag && hours_next == alarm_hour && minutes_next == alarm_minute) begin
          active_flag_next = 1'b1;
        end
      end
      OP_SET_TIME: begin
        hours_next   = cmd.hour;
        minutes_next = cmd.minute;
        seconds_next = cmd.second;
      end
      OP_SET_DATE: begin
        day_of_month_next = cmd.day;
        month_next        = cmd.month;
        year_next         = cmd.year;
        year_mod25_next   = cmd.year_mod25;
        weekday_next      = mod7_17(cmd.wd_sum);
      end
      OP_SET_ALARM: begin
        alarm_hour_next   = cmd.hour;
        alarm_minute_next = cmd.minute;
        armed_flag_next   = 1'b1;
      end
      OP_CLEAR: begin
        armed_flag_next  = 1'b0;
        active_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds      <= '0;
      minutes      <= '0;
      hours        <= '0;
      day_of_month <= 5'd1;
      month        <= 4'd1;
      year         <= DefMinYear;
      year_mod25   <= DefMinMod25;
      weekday      <= DefResetWeekday;
      alarm_hour   <= '0;
      alarm_minute <= '0;
      armed_flag   <= 1'b0;
      active_flag  <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (pop) begin
        seconds      <= seconds_next;
        minutes      <= minutes_next;
        hours        <= hours_next;
        day_of_month <= day_of_month_next;
        month        <= month_next;
        year         <= year_next;
        year_mod25   <= year_mod25_next;
        weekday      <= weekday_next;
        alarm_hour   <= alarm_hour_next;
        alarm_minute <= alarm_minute_next;
        armed_flag   <= armed_flag_next;
        active_flag  <= active_flag_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {5'd0, active_flag_next, armed_flag_next, alarm_minute_next,
                  alarm_hour_next, weekday_next, year_next, month_next,
                  day_of_month_next, hours_next, minutes_next, seconds_next, accepted};
    end
  end

  assert property (@(posedge clk) disable iff (rst) $rose(active_flag) |-> armed_flag)
    else $error("alarm went active while not armed");
  assert property (@(posedge clk) disable iff (rst)
    (pop && cmd.op == OP_REJECT) |=> $stable(year) && $stable(seconds) && $stable(armed_flag))
    else $error("rejected request changed the state");

endmodule

[dv/rtc_calendar_with_alarm_unit_tb.sv]
module rtc_calendar_with_alarm_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtc_pkg::*;

  localparam logic [InUserW-1:0] KindUnknownLow  = 3'd5;
  localparam logic [InUserW-1:0] KindUnknownHigh = 3'd7;
  localparam int DrainSlack = 8;
  localparam int ReportCap  = 40;
  localparam int PhaseItems = 150;

  // hour in the lowest bits
  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  second;
    logic [7:0]  minute;
    logic [7:0]  hour;
  } rtc_request_t;

  // accepted in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic        active;
    logic        armed;
    logic [5:0]  alarm_minute;
    logic [4:0]  alarm_hour;
    logic [2:0]  weekday;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        accepted;
  } rtc_status_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_data;

  rtc_calendar_with_alarm_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  int unsigned cal_sec, cal_min, cal_hour, cal_day, cal_month, cal_year, cal_wday;
  int unsigned alm_hour, alm_min;
  bit          alm_armed, alm_active;
  int unsigned reg_year_lo, reg_year_hi, reg_reset_wday;
  int unsigned sak_offsets[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  rtc_status_t pending_status_q[$];
  int unsigned mismatch_count;
  bit          sender_idle_on;
  bit          sink_stall_on;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("rtc_calendar_with_alarm_unit_tb failed");
    $finish;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    if (m == 2) return is_leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic void restart_calendar();
    cal_sec   = 0;
    cal_min   = 0;
    cal_hour  = 0;
    cal_day   = 1;
    cal_month = 1;
    cal_year  = reg_year_lo;
    cal_wday  = reg_reset_wday;
  endfunction

  function automatic void reset_calendar_model();
    reg_year_lo    = 32'(DefMinYear);
    reg_year_hi    = 32'(DefMaxYear);
    reg_reset_wday = 32'(DefResetWeekday);
    restart_calendar();
    alm_hour   = 0;
    alm_min    = 0;
    alm_armed  = 1'b0;
    alm_active = 1'b0;
  endfunction

  function automatic void advance_one_second();
    int unsigned day_carry;
    bit          wrapped;
    day_carry = 0;
    wrapped   = 1'b0;
    if (cal_sec >= 59) begin
      cal_sec = 0;
      if (cal_min < 59) begin
        cal_min++;
      end else begin
        cal_min = 0;
        if (cal_hour < 23) begin
          cal_hour++;
        end else begin
          cal_hour  = 0;
          day_carry = 1;
        end
      end
    end else begin
      cal_sec++;
    end
    // a day past the month length rolls over even without a carry
    if (cal_day + day_carry > month_length(cal_month, cal_year)) begin
      cal_day = 1;
      if (cal_month < 12) begin
        cal_month++;
      end else begin
        cal_month = 1;
        if (cal_year + 1 <= reg_year_hi) begin
          cal_year++;
        end else begin
          restart_calendar();
          wrapped = 1'b1;
        end
      end
    end else begin
      cal_day += day_carry;
    end
    if (!wrapped) cal_wday = (cal_wday + day_carry) % 7;
    if (alm_armed && cal_hour == alm_hour && cal_min == alm_min) alm_active = 1'b1;
  endfunction

  function automatic rtc_status_t apply_request(input logic [InUserW-1:0] kind,
                                                input rtc_request_t req);
    rtc_status_t st;
    logic [15:0] prev_year;
    int unsigned sy;
    bit          ok;
    ok = 1'b0;
    case (kind)
      KindTick: begin
        advance_one_second();
        ok = 1'b1;
      end
      KindSetTime: begin
        if (req.hour <= 23 && req.minute <= 59 && req.second <= 59) begin
          cal_hour = 32'(req.hour);
          cal_min  = 32'(req.minute);
          cal_sec  = 32'(req.second);
          ok = 1'b1;
        end
      end
      KindSetDate: begin
        if (req.day >= 1 && req.day <= 31 && req.month >= 1 && req.month <= 12 &&
            32'(req.year) >= reg_year_lo && 32'(req.year) <= reg_year_hi) begin
          prev_year = req.year - 16'd1;
          sy = 32'((req.month < 3) ? prev_year : req.year);
          cal_day   = 32'(req.day);
          cal_month = 32'(req.month);
          cal_year  = 32'(req.year);
          cal_wday  = (sy + sy / 4 + sy / 400 + sak_offsets[req.month - 1] + 32'(req.day)
                       - sy / 100) % 7;
          ok = 1'b1;
        end
      end
      KindSetAlarm: begin
        if (req.hour <= 23 && req.minute <= 59) begin
          alm_hour  = 32'(req.hour);
          alm_min   = 32'(req.minute);
          alm_armed = 1'b1;
          ok = 1'b1;
        end
      end
      KindClear: begin
        alm_armed  = 1'b0;
        alm_active = 1'b0;
        ok = 1'b1;
      end
      default: ;
    endcase
    st              = '0;
    st.accepted     = ok;
    st.second       = cal_sec[5:0];
    st.minute       = cal_min[5:0];
    st.hour         = cal_hour[4:0];
    st.day          = cal_day[4:0];
    st.month        = cal_month[3:0];
    st.year         = cal_year[15:0];
    st.weekday      = cal_wday[2:0];
    st.alarm_hour   = alm_hour[4:0];
    st.alarm_minute = alm_min[5:0];
    st.armed        = alm_armed;
    st.active       = alm_active;
    return st;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < ReportCap)
      $display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_fields(input logic [InUserW-1:0] kind, input logic [7:0] h,
                             input logic [7:0] mi, input logic [7:0] s, input logic [7:0] d,
                             input logic [7:0] mo, input logic [15:0] y);
    rtc_request_t req;
    int unsigned  gap;
    req = '{year: y, month: mo, day: d, second: s, minute: mi, hour: h};
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = req;
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_status_q.push_back(apply_request(kind, req));
    gap = sender_idle_on ? idle_len() : 0;
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      RegMinYear:      reg_year_lo    = 32'(value);
      RegMaxYear:      reg_year_hi    = 32'(value);
      RegResetWeekday: reg_reset_wday = 32'(value[2:0]);
      default: ;
    endcase
  endtask

  task automatic set_calendar_limits(input logic [15:0] lo, input logic [15:0] hi,
                                     input logic [2:0] wday);
    drain_results();
    write_register(RegMinYear, lo);
    write_register(RegMaxYear, hi);
    write_register(RegResetWeekday, 16'(wday));
  endtask

  function automatic logic [15:0] pick_year();
    if (reg_year_lo > reg_year_hi || $urandom_range(0, 7) == 0)
      return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0:       return 16'(reg_year_lo);
      1:       return 16'(reg_year_hi);
      default: return 16'($urandom_range(reg_year_hi, reg_year_lo));
    endcase
  endfunction

  // mostly well-formed requests aimed at rollovers and alarm hits
  task automatic random_item();
    int unsigned      r;
    logic [InUserW-1:0] kind;
    logic [7:0]       h, mi, s, d, mo;
    logic [15:0]      y;
    h  = 8'($urandom_range(0, 255));
    mi = 8'($urandom_range(0, 255));
    s  = 8'($urandom_range(0, 255));
    d  = 8'($urandom_range(0, 255));
    mo = 8'($urandom_range(0, 255));
    y  = 16'($urandom_range(0, 65535));
    r  = $urandom_range(0, 99);
    if (r < 45) begin
      kind = KindTick;
    end else if (r < 62) begin
      kind = KindSetTime;
      case ($urandom_range(0, 5))
        0, 1: begin
          h  = 8'd23;
          mi = 8'd59;
          s  = 8'($urandom_range(50, 59));
        end
        2: begin
          h  = 8'($urandom_range(0, 23));
          mi = 8'd59;
          s  = 8'($urandom_range(55, 59));
        end
        3, 4: begin
          h  = 8'($urandom_range(0, 23));
          mi = 8'($urandom_range(0, 59));
          s  = 8'($urandom_range(0, 59));
        end
        default: ;
      endcase
    end else if (r < 76) begin
      kind = KindSetDate;
      mo = 8'($urandom_range(1, 12));
      d  = 8'($urandom_range(0, 1) ? $urandom_range(28, 31) : $urandom_range(1, 31));
      y  = pick_year();
      case ($urandom_range(0, 9))
        0: begin
          d  = 8'd31;
          mo = 8'd12;
          y  = 16'(reg_year_hi);
        end
        1: begin
          d  = 8'd29;
          mo = 8'd2;
        end
        2:       d  = 8'($urandom_range(0, 255));
        3:       mo = 8'($urandom_range(0, 255));
        default: ;
      endcase
    end else if (r < 86) begin
      kind = KindSetAlarm;
      case ($urandom_range(0, 4))
        0, 1: begin
          h  = 8'(cal_hour);
          mi = 8'(cal_min);
        end
        2: begin
          h  = 8'(cal_hour);
          mi = 8'((cal_min + 1) % 60);
        end
        3: begin
          h  = 8'($urandom_range(0, 23));
          mi = 8'($urandom_range(0, 59));
        end
        default: ;
      endcase
    end else if (r < 92) begin
      kind = KindClear;
    end else begin
      kind = 3'($urandom_range(KindUnknownHigh, KindUnknownLow));
    end
    send_fields(kind, h, mi, s, d, mo, y);
  endtask

  task automatic test_reset_and_unknown();
    send_fields(KindTick, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    send_fields(KindUnknownLow, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 16'd2000);
    send_fields(KindUnknownHigh, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_request_checks();
    send_fields(KindSetTime, 8'd24, 8'd0, 8'd0, 8'd1, 8'd1, 16'd2000);
    send_fields(KindSetTime, 8'd0, 8'd60, 8'd0, 8'd1, 8'd1, 16'd2000);
    send_fields(KindSetTime, 8'd0, 8'd0, 8'd60, 8'd1, 8'd1, 16'd2000);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd2000);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd32, 8'd13, 16'd2000);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd15, 8'd6, 16'd1999);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd15, 8'd6, 16'd2100);
    send_fields(KindSetAlarm, 8'd24, 8'd60, 8'd0, 8'd1, 8'd1, 16'd2000);
  endtask

  task automatic test_calendar_edges();
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd29, 8'd2, 16'd2000);
    send_fields(KindSetTime, 8'd23, 8'd59, 8'd59, 8'd0, 8'd0, 16'd0);
    send_fields(KindTick, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd31, 8'd2, 16'd2001);
    send_fields(KindTick, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd31, 8'd12, 16'd2099);
    send_fields(KindSetTime, 8'd23, 8'd59, 8'd59, 8'd0, 8'd0, 16'd0);
    send_fields(KindTick, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
  endtask

  task automatic test_alarm();
    send_fields(KindSetAlarm, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    send_fields(KindSetTime, 8'd23, 8'd59, 8'd59, 8'd0, 8'd0, 16'd0);
    send_fields(KindTick, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    send_fields(KindTick, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    send_fields(KindClear, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
  endtask

  task automatic test_register_extremes();
    set_calendar_limits(16'd0, 16'hFFFF, 3'd0);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 16'd0);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd29, 8'd2, 16'd0);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd31, 8'd12, 16'hFFFF);
    send_fields(KindSetTime, 8'd23, 8'd59, 8'd59, 8'd0, 8'd0, 16'd0);
    send_fields(KindTick, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    // empty year window: every date is refused
    set_calendar_limits(16'd2100, 16'd2000, 3'd3);
    send_fields(KindSetDate, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 16'd2050);
    send_fields(KindTick, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned phase, n;
    logic [15:0] lo;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_calendar_limits(DefMinYear, DefMaxYear, DefResetWeekday);
        1: set_calendar_limits(16'd0, 16'hFFFF, 3'd0);
        2: set_calendar_limits(16'd1900, 16'd1901, 3'd3);
        default: begin
          lo = 16'($urandom_range(0, 65000));
          set_calendar_limits(lo, lo + 16'($urandom_range(0, 500)),
                              3'($urandom_range(0, 6)));
        end
      endcase
      for (n = 0; n < PhaseItems; n++) begin
        if (n % 30 == 0) begin
          sender_idle_on = ($urandom_range(0, 3) != 0);
          sink_stall_on  = ($urandom_range(0, 3) != 0);
        end
        if (n == PhaseItems / 2) drain_results();
        random_item();
      end
    end
  endtask

  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (sink_stall_on && stall_left == 0 && $urandom_range(0, 2) == 0)
        stall_left = idle_len();
      if (stall_left != 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rtc_status_t got, want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got = m_tdata;
      if (pending_status_q.size() == 0) begin
        report_mismatch("result with nothing pending", got, '0);
      end else begin
        want = pending_status_q.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
        if (got.second !== want.second)
          report_mismatch("second_now", 64'(got.second), 64'(want.second));
        if (got.minute !== want.minute)
          report_mismatch("minute_now", 64'(got.minute), 64'(want.minute));
        if (got.hour !== want.hour)
          report_mismatch("hour_now", 64'(got.hour), 64'(want.hour));
        if (got.day !== want.day)
          report_mismatch("day_now", 64'(got.day), 64'(want.day));
        if (got.month !== want.month)
          report_mismatch("month_now", 64'(got.month), 64'(want.month));
        if (got.year !== want.year)
          report_mismatch("year_now", 64'(got.year), 64'(want.year));
        if (got.weekday !== want.weekday)
          report_mismatch("weekday_now", 64'(got.weekday), 64'(want.weekday));
        if (got.alarm_hour !== want.alarm_hour)
          report_mismatch("alarm_hour_now", 64'(got.alarm_hour), 64'(want.alarm_hour));
        if (got.alarm_minute !== want.alarm_minute)
          report_mismatch("alarm_minute_now", 64'(got.alarm_minute),
                          64'(want.alarm_minute));
        if (got.armed !== want.armed)
          report_mismatch("alarm_armed", 64'(got.armed), 64'(want.armed));
        if (got.active !== want.active)
          report_mismatch("alarm_active", 64'(got.active), 64'(want.active));
      end
    end
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    sender_idle_on = 1'b1;
    sink_stall_on  = 1'b1;
    reset_calendar_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_and_unknown();
    test_request_checks();
    test_calendar_edges();
    test_alarm();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) begin
      $display("rtc_calendar_with_alarm_unit_tb passed");
    end else begin
      $display("rtc_calendar_with_alarm_unit_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rtc_pkg.sv
hdl/rtc_front.sv
hdl/rtc_queue.sv
hdl/rtc_back.sv
hdl/rtc_calendar_with_alarm_unit.sv
dv/rtc_calendar_with_alarm_unit_tb.sv
